@@ hdl/bspa_pkg.sv @@
// ----------------------------------------------------------------------------
// bspa_pkg
// Shared types, codes and helpers of the barrier slot pool allocator.
// ----------------------------------------------------------------------------
package bspa_pkg;

  localparam int NUM_POOLS_DEF      = 4;
  localparam int SLOTS_PER_POOL_DEF = 8;

  localparam int CTX_W   = 16;
  localparam int ROOT_W  = 16;
  localparam int CNT_W   = 9;
  localparam int POOL_W  = 2;
  localparam int SLOT_W  = 3;
  localparam int PEN_W   = 3;
  localparam int SPP_W   = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  localparam logic [CNT_W-1:0] COUNT_MAX = 9'd256;

  localparam logic [PEN_W-1:0] PEN_RESET = 3'd4;
  localparam logic [SPP_W-1:0] SPP_RESET = 4'd8;

  localparam logic [CFG_IDX_W-1:0] CFG_POOLS_ENABLED  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_PER_POOL = 1'b1;

  localparam logic REQ_SETUP   = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  typedef struct packed {
    logic [CTX_W-1:0]  ctx;
    logic [ROOT_W-1:0] root;
    logic [CNT_W-1:0]  alloc_cnt;
    logic [CNT_W-1:0]  free_cnt;
    logic [CNT_W-1:0]  grp_size;
  } entry_t;

  typedef struct packed {
    logic we;
    logic busy_set;
    logic busy_clr;
  } tbl_cmd_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v >= COUNT_MAX) ? COUNT_MAX : CNT_W'(v + 1'b1);
  endfunction

endpackage

@@ hdl/bspa_table.sv @@
// ----------------------------------------------------------------------------
// bspa_table
// Slot entry memory (registered read) and per-slot busy flags.
// ----------------------------------------------------------------------------
module bspa_table #(
  parameter int DEPTH = bspa_pkg::NUM_POOLS_DEF * bspa_pkg::SLOTS_PER_POOL_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [AW-1:0]      rd_addr,
  output bspa_pkg::entry_t   rd_data,
  input  bspa_pkg::tbl_cmd_t cmd,
  input  logic [AW-1:0]      wr_addr,
  input  bspa_pkg::entry_t   wr_data,
  output logic [DEPTH-1:0]   busy
);

  bspa_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= '0;
    end else if (cmd.busy_set) begin
      busy[wr_addr] <= 1'b1;
    end else if (cmd.busy_clr) begin
      busy[wr_addr] <= 1'b0;
    end
  end

endmodule

@@ hdl/bspa_ctrl.sv @@
// ----------------------------------------------------------------------------
// bspa_ctrl
// Request sequencer: match scan, round-robin free search, release update.
// ----------------------------------------------------------------------------
module bspa_ctrl #(
  parameter int NUM_POOLS      = bspa_pkg::NUM_POOLS_DEF,
  parameter int SLOTS_PER_POOL = bspa_pkg::SLOTS_PER_POOL_DEF,
  parameter int DEPTH = NUM_POOLS * SLOTS_PER_POOL,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int PCW   = $clog2(NUM_POOLS + 1),
  parameter int SCW   = $clog2(SLOTS_PER_POOL + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [PCW-1:0]              np,
  input  logic [SCW-1:0]              ns,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  logic                        req_type,
  input  logic [bspa_pkg::CTX_W-1:0]  context_id,
  input  logic [bspa_pkg::ROOT_W-1:0] root_proc,
  input  logic [bspa_pkg::CNT_W-1:0]  local_procs,
  input  logic [bspa_pkg::POOL_W-1:0] pool_sel,
  input  logic [bspa_pkg::SLOT_W-1:0] slot_sel,
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output logic                        granted,
  output logic                        newly_taken,
  output logic [bspa_pkg::POOL_W-1:0] pool_out,
  output logic [bspa_pkg::SLOT_W-1:0] slot_out,
  output logic                        slot_freed,
  output logic [AW-1:0]               rd_addr,
  input  bspa_pkg::entry_t            rd_data,
  output bspa_pkg::tbl_cmd_t          cmd,
  output logic [AW-1:0]               wr_addr,
  output bspa_pkg::entry_t            wr_data,
  input  logic [DEPTH-1:0]            busy
);

  localparam int PIW = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
  localparam int SIW = (SLOTS_PER_POOL > 1) ? $clog2(SLOTS_PER_POOL) : 1;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MSCAN  = 3'd1;
  localparam logic [2:0] ST_FSCAN  = 3'd2;
  localparam logic [2:0] ST_RREAD  = 3'd3;
  localparam logic [2:0] ST_RESULT = 3'd4;

  logic [2:0] state;

  logic [bspa_pkg::CTX_W-1:0]  ctx_q;
  logic [bspa_pkg::ROOT_W-1:0] root_q;
  logic [bspa_pkg::CNT_W-1:0]  procs_q;
  logic [AW-1:0]               rel_addr_q;

  logic [PIW-1:0] scan_p, cmp_p, f_p, last_pool;
  logic [SIW-1:0] scan_s, cmp_s, f_s;
  logic [PCW-1:0] f_cnt;
  logic           iss_done, cmp_valid;

  logic                        r_g, r_t, r_f;
  logic [PIW-1:0]              r_p;
  logic [SIW-1:0]              r_s;

  logic [AW-1:0]          scan_addr, cmp_addr, f_addr, rel_addr_in;
  logic                   rel_ok, hit_m, f_hit, rel_done, scan_s_last, scan_p_last;
  logic                   f_s_last, f_cnt_last;
  logic [bspa_pkg::CNT_W-1:0] new_free;
  logic [PIW-1:0]         last_nxt, f_nxt;

  function automatic logic [PIW-1:0] pool_nxt(input logic [PIW-1:0] p,
                                               input logic [PCW-1:0] n);
    return ((PCW+1)'(p) + 1'b1 >= (PCW+1)'(n)) ? '0 : PIW'(p + 1'b1);
  endfunction

  assign req_stall = (state != ST_IDLE);

  always_comb begin
    scan_addr   = AW'(32'(scan_p) * SLOTS_PER_POOL + 32'(scan_s));
    cmp_addr    = AW'(32'(cmp_p) * SLOTS_PER_POOL + 32'(cmp_s));
    f_addr      = AW'(32'(f_p) * SLOTS_PER_POOL + 32'(f_s));
    rel_addr_in = AW'(32'(pool_sel) * SLOTS_PER_POOL + 32'(slot_sel));
    rel_ok      = (32'(pool_sel) < NUM_POOLS) && (32'(slot_sel) < SLOTS_PER_POOL);

    scan_s_last = ((SCW+1)'(scan_s) + 1'b1 >= (SCW+1)'(ns));
    scan_p_last = ((PCW+1)'(scan_p) + 1'b1 >= (PCW+1)'(np));
    f_s_last    = ((SCW+1)'(f_s) + 1'b1 >= (SCW+1)'(ns));
    f_cnt_last  = ((PCW+1)'(f_cnt) + 1'b1 >= (PCW+1)'(np));
    last_nxt    = pool_nxt(last_pool, np);
    f_nxt       = pool_nxt(f_p, np);

    hit_m = (state == ST_MSCAN) && cmp_valid && busy[cmp_addr] &&
            (rd_data.ctx == ctx_q) && (rd_data.root == root_q);
    f_hit = (state == ST_FSCAN) && (ns != '0) && !busy[f_addr];

    new_free = bspa_pkg::sat_inc(rd_data.free_cnt);
    rel_done = (new_free == rd_data.grp_size);

    rd_addr = (state == ST_IDLE) ? rel_addr_in : scan_addr;

    cmd     = '0;
    wr_addr = cmp_addr;
    wr_data = rd_data;
    if (hit_m) begin
      cmd.we             = 1'b1;
      wr_data.alloc_cnt  = bspa_pkg::sat_inc(rd_data.alloc_cnt);
      wr_data.grp_size   = procs_q;
    end else if (f_hit) begin
      cmd.we             = 1'b1;
      cmd.busy_set       = 1'b1;
      wr_addr            = f_addr;
      wr_data.ctx        = ctx_q;
      wr_data.root       = root_q;
      wr_data.alloc_cnt  = bspa_pkg::CNT_W'(1);
      wr_data.free_cnt   = '0;
      wr_data.grp_size   = procs_q;
    end else if (state == ST_RREAD) begin
      cmd.we             = 1'b1;
      cmd.busy_clr       = rel_done;
      wr_addr            = rel_addr_q;
      wr_data.free_cnt   = new_free;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
      last_pool <= '0;
      cmp_valid <= 1'b0;
    end else begin
      rsp_valid <= (state == ST_RESULT) || (rsp_valid && rsp_stall);
      unique case (state)
        ST_IDLE: begin
          if (req_valid) begin
            ctx_q      <= context_id;
            root_q     <= root_proc;
            procs_q    <= local_procs;
            rel_addr_q <= rel_addr_in;
            r_g <= 1'b0;
            r_t <= 1'b0;
            r_f <= 1'b0;
            r_p <= '0;
            r_s <= '0;
            if (req_type == bspa_pkg::REQ_SETUP) begin
              state     <= ST_MSCAN;
              scan_p    <= '0;
              scan_s    <= '0;
              cmp_valid <= 1'b0;
              iss_done  <= (np == '0) || (ns == '0);
            end else if (rel_ok && busy[rel_addr_in]) begin
              state <= ST_RREAD;
            end else begin
              state <= ST_RESULT;
            end
          end
        end
        ST_MSCAN: begin
          if (hit_m) begin
            r_g       <= 1'b1;
            r_p       <= cmp_p;
            r_s       <= cmp_s;
            cmp_valid <= 1'b0;
            state     <= ST_RESULT;
          end else if (iss_done && !cmp_valid) begin
            f_p   <= last_nxt;
            f_s   <= '0;
            f_cnt <= '0;
            state <= (np == '0) ? ST_RESULT : ST_FSCAN;
          end else begin
            cmp_valid <= !iss_done;
            cmp_p     <= scan_p;
            cmp_s     <= scan_s;
            if (!iss_done) begin
              if (scan_s_last) begin
                scan_s <= '0;
                if (scan_p_last) begin
                  iss_done <= 1'b1;
                end else begin
                  scan_p <= PIW'(scan_p + 1'b1);
                end
              end else begin
                scan_s <= SIW'(scan_s + 1'b1);
              end
            end
          end
        end
        ST_FSCAN: begin
          if (f_hit) begin
            r_g       <= 1'b1;
            r_t       <= 1'b1;
            r_p       <= f_p;
            r_s       <= f_s;
            last_pool <= f_p;
            state     <= ST_RESULT;
          end else if (f_s_last) begin
            f_s <= '0;
            if (f_cnt_last) begin
              state <= ST_RESULT;
            end else begin
              f_cnt <= PCW'(f_cnt + 1'b1);
              f_p   <= f_nxt;
            end
          end else begin
            f_s <= SIW'(f_s + 1'b1);
          end
        end
        ST_RREAD: begin
          r_f   <= rel_done;
          state <= ST_RESULT;
        end
        ST_RESULT: begin
          if (!rsp_valid || !rsp_stall) begin
            granted     <= r_g;
            newly_taken <= r_t;
            pool_out    <= bspa_pkg::POOL_W'(r_p);
            slot_out    <= bspa_pkg::SLOT_W'(r_s);
            slot_freed  <= r_f;
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ hdl/barrier_slot_pool_allocator.sv @@
// ----------------------------------------------------------------------------
// barrier_slot_pool_allocator
// Barrier slot table with pooled round-robin allocation and release counting.
// ----------------------------------------------------------------------------
// Setup: a match scan (one table read per cycle), then a free search if no
//   match is found, then the output is loaded (waits on a stall).
// Release: entry read and free-count update; skipped if the slot is already free.
// One transaction in flight; the next is accepted once the result is loaded.
// Reset clears all busy flags and the last-used pool and sets config to its
//   defaults; no clearing pass over the entry memory.
module barrier_slot_pool_allocator #(
  parameter int NUM_POOLS      = bspa_pkg::NUM_POOLS_DEF,
  parameter int SLOTS_PER_POOL = bspa_pkg::SLOTS_PER_POOL_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bspa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bspa_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  logic                            req_type,
  input  logic [bspa_pkg::CTX_W-1:0]      context_id,
  input  logic [bspa_pkg::ROOT_W-1:0]     root_proc,
  input  logic [bspa_pkg::CNT_W-1:0]      local_procs,
  input  logic [bspa_pkg::POOL_W-1:0]     pool_sel,
  input  logic [bspa_pkg::SLOT_W-1:0]     slot_sel,
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output logic                            granted,
  output logic                            newly_taken,
  output logic [bspa_pkg::POOL_W-1:0]     pool_out,
  output logic [bspa_pkg::SLOT_W-1:0]     slot_out,
  output logic                            slot_freed
);

  localparam int DEPTH = NUM_POOLS * SLOTS_PER_POOL;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PCW   = $clog2(NUM_POOLS + 1);
  localparam int SCW   = $clog2(SLOTS_PER_POOL + 1);

  logic [bspa_pkg::PEN_W-1:0] pools_enabled;
  logic [bspa_pkg::SPP_W-1:0] slots_per_pool;
  logic [PCW-1:0]             np;
  logic [SCW-1:0]             ns;

  logic [AW-1:0]      rd_addr, wr_addr;
  bspa_pkg::entry_t   rd_data, wr_data;
  bspa_pkg::tbl_cmd_t cmd;
  logic [DEPTH-1:0]   busy;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pools_enabled  <= bspa_pkg::PEN_RESET;
      slots_per_pool <= bspa_pkg::SPP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bspa_pkg::CFG_POOLS_ENABLED: begin
          pools_enabled <= cfg_data[bspa_pkg::PEN_W-1:0];
        end
        bspa_pkg::CFG_SLOTS_PER_POOL: begin
          slots_per_pool <= cfg_data[bspa_pkg::SPP_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    np = (32'(pools_enabled) > NUM_POOLS) ? PCW'(NUM_POOLS) : PCW'(pools_enabled);
    ns = (32'(slots_per_pool) > SLOTS_PER_POOL) ? SCW'(SLOTS_PER_POOL)
                                                : SCW'(slots_per_pool);
  end

  bspa_table #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .cmd     (cmd),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .busy    (busy)
  );

  bspa_ctrl #(
    .NUM_POOLS      (NUM_POOLS),
    .SLOTS_PER_POOL (SLOTS_PER_POOL),
    .DEPTH          (DEPTH),
    .AW             (AW),
    .PCW            (PCW),
    .SCW            (SCW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .np          (np),
    .ns          (ns),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req_type    (req_type),
    .context_id  (context_id),
    .root_proc   (root_proc),
    .local_procs (local_procs),
    .pool_sel    (pool_sel),
    .slot_sel    (slot_sel),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .granted     (granted),
    .newly_taken (newly_taken),
    .pool_out    (pool_out),
    .slot_out    (slot_out),
    .slot_freed  (slot_freed),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .cmd         (cmd),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .busy        (busy)
  );

endmodule

@@ hdl/bspa_checker.sv @@
// ----------------------------------------------------------------------------
// bspa_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bspa_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_stall,
  input logic                        rsp_valid,
  input logic                        rsp_stall,
  input logic                        granted,
  input logic                        newly_taken,
  input logic [bspa_pkg::POOL_W-1:0] pool_out,
  input logic [bspa_pkg::SLOT_W-1:0] slot_out,
  input logic                        slot_freed
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(granted) &&
      $stable(newly_taken) && $stable(pool_out) && $stable(slot_out) &&
      $stable(slot_freed))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request accepted while previous still in work");

  a_no_grant_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !granted |-> !newly_taken && pool_out == '0 && slot_out == '0)
    else $error("ungranted result carries slot fields");

  a_kind_exclusive: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && slot_freed |-> !granted && !newly_taken)
    else $error("release result mixed with setup fields");

endmodule

bind barrier_slot_pool_allocator bspa_checker u_bspa_checker (.*);
